// ===== design/gjpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid jump point finder package
// Shared widths, command codes and direction tables.
// ----------------------------------------------------------------------------
package gjpf_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int COORD_W     = 8;
   localparam int MAP_DEPTH   = 65536;
   localparam int ADDR_W      = 16;
   localparam int POS_W       = 11;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] DIR_LAST = 3'd7;

   typedef struct packed {
      logic                cmd;
      logic [COORD_W-1:0]  cell_x;
      logic [COORD_W-1:0]  cell_y;
      logic                open_bit;
   } req_word_type;

   typedef struct packed {
      logic [2:0]          direction;
      logic                found;
      logic [COORD_W-1:0]  jump_x;
      logic [COORD_W-1:0]  jump_y;
      logic [COORD_W-1:0]  step_count;
      logic                last;
   } rsp_word_type;

   function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
      case (d)
         3'd1, 3'd2, 3'd3: dir_dx = 2'sd1;
         3'd5, 3'd6, 3'd7: dir_dx = -2'sd1;
         default:          dir_dx = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
      case (d)
         3'd0, 3'd1, 3'd7: dir_dy = -2'sd1;
         3'd3, 3'd4, 3'd5: dir_dy = 2'sd1;
         default:          dir_dy = 2'sd0;
      endcase
   endfunction

endpackage

// ===== design/gjpf_stream_if.sv =====
// ----------------------------------------------------------------------------
// Grid jump point finder stream interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface gjpf_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/gjpf_walker.sv =====
// ----------------------------------------------------------------------------
// Grid jump point walker
// Sequencer that probes the cell map one cell at a time through one read port.
// ----------------------------------------------------------------------------
module gjpf_walker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gjpf_pkg::COORD_W-1:0]    start_x,
   input  logic [gjpf_pkg::COORD_W-1:0]    start_y,
   output logic                            busy,
   output logic                            map_re,
   output logic [gjpf_pkg::ADDR_W-1:0]     map_addr,
   input  logic                            map_rdata,
   output logic                            res_valid,
   input  logic                            res_ready,
   output gjpf_pkg::rsp_word_type          res_word
);

   typedef enum logic [3:0] {
      S_IDLE, S_MAIN, S_SIDE_A, S_SIDE_B, S_SIDE_C, S_SIDE_D,
      S_SUB, S_SUBA, S_SUBB, S_SUBC, S_SUBD, S_EMIT, S_WAIT
   } state_type;

   function automatic logic [gjpf_pkg::POS_W-1:0] ext2(input logic [1:0] v);
      ext2 = {{(gjpf_pkg::POS_W-2){v[1]}}, v};
   endfunction

   function automatic logic [gjpf_pkg::POS_W-1:0] unit1(input logic b);
      unit1 = {{(gjpf_pkg::POS_W-1){1'b0}}, b};
   endfunction

   function automatic logic [gjpf_pkg::POS_W-1:0] widen(
      input logic [gjpf_pkg::COORD_W-1:0] v);
      widen = {{(gjpf_pkg::POS_W-gjpf_pkg::COORD_W){1'b0}}, v};
   endfunction

   state_type state_ff;
   logic ph_ff, ok_ff;
   logic [2:0] dir_ff, next_dir;
   logic [gjpf_pkg::POS_W-1:0] cx_ff, cy_ff, sx_ff, sy_ff;
   logic [gjpf_pkg::POS_W-1:0] px_ff, py_ff;
   logic [8:0] k_ff;
   logic found_ff;
   logic [7:0] jx_ff, jy_ff, js_ff;
   logic sa_ff, sb_ff;
   logic subh_ff;
   logic res_valid_ff;
   gjpf_pkg::rsp_word_type res_word_ff;
   logic in_sub, is_diag, probe_ok, open_now;
   logic [1:0] sdx, sdy, udx, udy;
   logic [gjpf_pkg::POS_W-1:0] dxe, dye, pdx, pdy, ox, oy, qx, qy;
   logic [7:0] kk;

   always_comb begin
      sdx = gjpf_pkg::dir_dx(dir_ff);
      sdy = gjpf_pkg::dir_dy(dir_ff);
      next_dir = dir_ff + 3'd1;
      is_diag = dir_ff[0];
      in_sub = (state_ff == S_SUB) || (state_ff == S_SUBA) || (state_ff == S_SUBB)
               || (state_ff == S_SUBC) || (state_ff == S_SUBD);
      if (in_sub) begin
         udx = subh_ff ? sdx : 2'b00;
         udy = subh_ff ? 2'b00 : sdy;
      end else begin
         udx = sdx;
         udy = sdy;
      end
      dxe = ext2(sdx);
      dye = ext2(sdy);
      pdx = ext2(udx);
      pdy = ext2(udy);
      ox = unit1(|udy);
      oy = unit1(|udx);
      case (state_ff)
         S_SIDE_A: begin
            if (is_diag) begin
               qx = cx_ff;
               qy = cy_ff - dye;
            end else begin
               qx = cx_ff + ox;
               qy = cy_ff + oy;
            end
         end
         S_SIDE_B: begin
            if (is_diag) begin
               qx = cx_ff + dxe;
               qy = cy_ff - dye;
            end else begin
               qx = cx_ff + ox + pdx;
               qy = cy_ff + oy + pdy;
            end
         end
         S_SIDE_C: begin
            if (is_diag) begin
               qx = cx_ff - dxe;
               qy = cy_ff;
            end else begin
               qx = cx_ff - ox;
               qy = cy_ff - oy;
            end
         end
         S_SIDE_D: begin
            if (is_diag) begin
               qx = cx_ff - dxe;
               qy = cy_ff + dye;
            end else begin
               qx = cx_ff - ox + pdx;
               qy = cy_ff - oy + pdy;
            end
         end
         S_SUBA: begin
            qx = px_ff + ox;
            qy = py_ff + oy;
         end
         S_SUBB: begin
            qx = px_ff + ox + pdx;
            qy = py_ff + oy + pdy;
         end
         S_SUBC: begin
            qx = px_ff - ox;
            qy = py_ff - oy;
         end
         S_SUBD: begin
            qx = px_ff - ox + pdx;
            qy = py_ff - oy + pdy;
         end
         default: begin
            qx = px_ff;
            qy = py_ff;
         end
      endcase
      probe_ok = (qx < gjpf_pkg::POS_W'(gjpf_pkg::GRID_WIDTH))
                 && (qy < gjpf_pkg::POS_W'(gjpf_pkg::GRID_HEIGHT));
      map_addr = {qy[7:0], qx[7:0]};
      map_re = probe_ok;
   end

   assign busy = (state_ff != S_IDLE);
   assign res_valid = res_valid_ff;
   assign res_word = res_word_ff;

   // Map data returns in the cycle after a probe is issued: each probing state
   // is held for an issue phase (ph=0) and then a consume phase (ph=1).
   assign open_now = ok_ff & map_rdata;

   assign kk = (k_ff > 9'd255) ? 8'd255 : k_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         ok_ff <= probe_ok;
         if (state_ff != S_IDLE && state_ff != S_EMIT && state_ff != S_WAIT && !ph_ff) begin
            ph_ff <= 1'b1;
         end else begin
            ph_ff <= 1'b0;
            case (state_ff)
               S_IDLE: begin
                  if (start) begin
                     dir_ff <= 3'd0;
                     sx_ff <= widen(start_x);
                     sy_ff <= widen(start_y);
                     px_ff <= widen(start_x) + ext2(gjpf_pkg::dir_dx(3'd0));
                     py_ff <= widen(start_y) + ext2(gjpf_pkg::dir_dy(3'd0));
                     k_ff <= 9'd1;
                     state_ff <= S_MAIN;
                  end
               end
               S_MAIN: begin
                  if (!open_now || k_ff > 9'd300) begin
                     found_ff <= (k_ff > 9'd1);
                     jx_ff <= 8'(px_ff - pdx);
                     jy_ff <= 8'(py_ff - pdy);
                     js_ff <= (k_ff - 9'd1 > 9'd255) ? 8'd255 : 8'(k_ff - 9'd1);
                     state_ff <= S_EMIT;
                  end else begin
                     cx_ff <= px_ff;
                     cy_ff <= py_ff;
                     state_ff <= S_SIDE_A;
                  end
               end
               S_SIDE_A: begin
                  sa_ff <= !open_now;
                  state_ff <= S_SIDE_B;
               end
               S_SIDE_B: begin
                  if (sa_ff && open_now) begin
                     found_ff <= 1'b1;
                     jx_ff <= cx_ff[7:0];
                     jy_ff <= cy_ff[7:0];
                     js_ff <= kk;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SIDE_C;
                  end
               end
               S_SIDE_C: begin
                  sb_ff <= !open_now;
                  state_ff <= S_SIDE_D;
               end
               S_SIDE_D: begin
                  if (sb_ff && open_now) begin
                     found_ff <= 1'b1;
                     jx_ff <= cx_ff[7:0];
                     jy_ff <= cy_ff[7:0];
                     js_ff <= kk;
                     state_ff <= S_EMIT;
                  end else if (is_diag) begin
                     subh_ff <= 1'b0;
                     px_ff <= cx_ff;
                     py_ff <= cy_ff + dye;
                     state_ff <= S_SUB;
                  end else begin
                     px_ff <= cx_ff + pdx;
                     py_ff <= cy_ff + pdy;
                     k_ff <= k_ff + 9'd1;
                     state_ff <= S_MAIN;
                  end
               end
               S_SUB: begin
                  if (!open_now) begin
                     if (!subh_ff) begin
                        subh_ff <= 1'b1;
                        px_ff <= cx_ff + dxe;
                        py_ff <= cy_ff;
                        state_ff <= S_SUB;
                     end else begin
                        px_ff <= cx_ff + dxe;
                        py_ff <= cy_ff + dye;
                        k_ff <= k_ff + 9'd1;
                        state_ff <= S_MAIN;
                     end
                  end else begin
                     state_ff <= S_SUBA;
                  end
               end
               S_SUBA: begin
                  sa_ff <= !open_now;
                  state_ff <= S_SUBB;
               end
               S_SUBB: begin
                  if (sa_ff && open_now) begin
                     found_ff <= 1'b1;
                     jx_ff <= cx_ff[7:0];
                     jy_ff <= cy_ff[7:0];
                     js_ff <= kk;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SUBC;
                  end
               end
               S_SUBC: begin
                  sb_ff <= !open_now;
                  state_ff <= S_SUBD;
               end
               S_SUBD: begin
                  if (sb_ff && open_now) begin
                     found_ff <= 1'b1;
                     jx_ff <= cx_ff[7:0];
                     jy_ff <= cy_ff[7:0];
                     js_ff <= kk;
                     state_ff <= S_EMIT;
                  end else begin
                     px_ff <= px_ff + pdx;
                     py_ff <= py_ff + pdy;
                     state_ff <= S_SUB;
                  end
               end
               S_EMIT: begin
                  res_word_ff.direction <= dir_ff;
                  res_word_ff.found <= found_ff;
                  res_word_ff.jump_x <= found_ff ? jx_ff : 8'd0;
                  res_word_ff.jump_y <= found_ff ? jy_ff : 8'd0;
                  res_word_ff.step_count <= found_ff ? js_ff : 8'd0;
                  res_word_ff.last <= (dir_ff == gjpf_pkg::DIR_LAST);
                  res_valid_ff <= 1'b1;
                  state_ff <= S_WAIT;
               end
               S_WAIT: begin
                  if (res_ready) begin
                     res_valid_ff <= 1'b0;
                     if (dir_ff == gjpf_pkg::DIR_LAST) begin
                        state_ff <= S_IDLE;
                     end else begin
                        dir_ff <= next_dir;
                        px_ff <= sx_ff + ext2(gjpf_pkg::dir_dx(next_dir));
                        py_ff <= sy_ff + ext2(gjpf_pkg::dir_dy(next_dir));
                        k_ff <= 9'd1;
                        state_ff <= S_MAIN;
                     end
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

endmodule

// ===== design/grid_jump_point_finder_top.sv =====
// ----------------------------------------------------------------------------
// Grid jump point finder
// Keeps a 256 x 256 open/blocked bitmap and answers jump point queries.
// ----------------------------------------------------------------------------
// The req channel takes one word per item. A write word sets one map cell.
// A query word returns eight rsp words, one per direction from north
// clockwise, the last one flagged with last.
// Each probe of a walk reads one map cell through the single read port of
// the map memory; a straight step probes five cells.
// A diagonal step probes five cells and then every cell of its two straight
// sub-walks, five probes for each open one.
// One query is handled at a time: req ready is low until the eighth rsp
// word has been taken. A stalled receiver simply holds the walk.
// After reset the block sweeps the map to blocked, one cell per cycle;
// req ready stays low meanwhile.
// ----------------------------------------------------------------------------
module grid_jump_point_finder_top (
   input logic clock,
   input logic reset,
   gjpf_stream_if.sink   req,
   gjpf_stream_if.source rsp
);

   logic map_mem [gjpf_pkg::MAP_DEPTH];
   logic clr_ff;
   logic [gjpf_pkg::ADDR_W-1:0] clr_addr_ff;
   logic walk_busy, map_re, map_rdata_ff;
   logic [gjpf_pkg::ADDR_W-1:0] map_addr;
   logic wr_en;
   gjpf_pkg::req_word_type rq;

   assign rq = req.data;
   assign req.ready = !clr_ff && !walk_busy;
   assign wr_en = req.valid && req.ready && (rq.cmd == gjpf_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + {{(gjpf_pkg::ADDR_W-1){1'b0}}, 1'b1};
         if (&clr_addr_ff) clr_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         map_mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         map_mem[{rq.cell_y, rq.cell_x}] <= rq.open_bit;
      end
      if (map_re) begin
         map_rdata_ff <= map_mem[map_addr];
      end
   end

   gjpf_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (req.valid && req.ready && rq.cmd == gjpf_pkg::CMD_QUERY),
      .start_x   (rq.cell_x),
      .start_y   (rq.cell_y),
      .busy      (walk_busy),
      .map_re    (map_re),
      .map_addr  (map_addr),
      .map_rdata (map_rdata_ff),
      .res_valid (rsp.valid),
      .res_ready (rsp.ready),
      .res_word  (rsp.data)
   );

endmodule

// ===== design/gjpf_checker.sv =====
// ----------------------------------------------------------------------------
// Grid jump point finder checker
// Port level checks of the result stream and of the req handshake.
// ----------------------------------------------------------------------------
module gjpf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input gjpf_pkg::rsp_word_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.direction == gjpf_pkg::DIR_LAST)))
      else $error("last flag does not match direction");

   a_nf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.step_count == 8'd0)
      else $error("not found word carries a step count");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("input taken during a query");

endmodule

bind grid_jump_point_finder_top gjpf_checker u_gjpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
